// File: rtl/tlbclk_pkg.sv
package tlbclk_pkg;

    localparam int CFG_W = 5;
    localparam int SLOT_W = 4;
    localparam int COUNT_W = 32;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 2;

    localparam logic [APB_ADDR_W-1:0] ADDR_ACTIVE_ENTRIES = 2'd0;
    localparam logic [CFG_W-1:0] ACTIVE_ENTRIES_RESET = 5'd16;

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_FILL = 1'b1;

    typedef struct packed {
        logic load;
        logic lookup_commit;
        logic fill_free;
        logic sweep_clear;
        logic fill_victim;
    } tlbclk_cmd_t;

    typedef struct packed {
        logic is_fill;
        logic has_invalid;
        logic ptr_used;
        logic out_free;
    } tlbclk_status_t;

endpackage

// File: rtl/tlbclk_ctrl.sv
module tlbclk_ctrl
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  tlbclk_pkg::tlbclk_status_t status,
    output tlbclk_pkg::tlbclk_cmd_t    cmd
);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_LOOK,
        ST_SWEEP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   in_ready_next;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        in_ready_next = in_ready_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_LOOK;
                    in_ready_next = 1'b0;
                end
            end
            ST_LOOK:
            begin
                if (status.is_fill == tlbclk_pkg::KIND_LOOKUP)
                begin
                    if (status.out_free)
                    begin
                        cmd.lookup_commit = 1'b1;
                        state_next = ST_IDLE;
                        in_ready_next = 1'b1;
                    end
                end
                else if (status.has_invalid)
                begin
                    if (status.out_free)
                    begin
                        cmd.fill_free = 1'b1;
                        state_next = ST_IDLE;
                        in_ready_next = 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (status.ptr_used)
                begin
                    cmd.sweep_clear = 1'b1;
                end
                else if (status.out_free)
                begin
                    cmd.fill_victim = 1'b1;
                    state_next = ST_IDLE;
                    in_ready_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                in_ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            in_ready_reg <= in_ready_next;
        end
    end

    assign in_ready = in_ready_reg;

endmodule

// File: rtl/tlbclk_dp.sv
module tlbclk_dp
#(
    parameter int ENTRIES = 16,
    parameter int PAGE_BITS = 20,
    parameter int FRAME_BITS = 20
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  tlbclk_pkg::tlbclk_cmd_t            cmd,
    output tlbclk_pkg::tlbclk_status_t         status,
    input  logic [tlbclk_pkg::CFG_W-1:0]       active_entries,
    input  logic                               kind,
    input  logic [PAGE_BITS-1:0]               page_number,
    input  logic [FRAME_BITS-1:0]              frame_in,
    input  logic                               write_access,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               hit,
    output logic [FRAME_BITS-1:0]              frame_out,
    output logic [tlbclk_pkg::SLOT_W-1:0]      slot,
    output logic [tlbclk_pkg::COUNT_W-1:0]     hit_total
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CMP_W = (IDX_W + 1 > tlbclk_pkg::CFG_W) ? IDX_W + 1 : tlbclk_pkg::CFG_W;

    logic                              kind_reg;
    logic [PAGE_BITS-1:0]              page_reg;
    logic [FRAME_BITS-1:0]             frame_in_reg;
    logic                              write_reg;
    logic [IDX_W-1:0]                  ptr_reg;
    logic [IDX_W-1:0]                  ptr_next;
    logic [ENTRIES-1:0]                valid_reg;
    logic [ENTRIES-1:0]                valid_next;
    logic [ENTRIES-1:0]                used_reg;
    logic [ENTRIES-1:0]                used_next;
    logic [ENTRIES-1:0]                dirty_reg;
    logic [ENTRIES-1:0]                dirty_next;
    logic [tlbclk_pkg::COUNT_W-1:0]    count_reg;
    logic [tlbclk_pkg::COUNT_W-1:0]    count_next;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic                              hit_reg;
    logic                              hit_next;
    logic [FRAME_BITS-1:0]             frame_out_reg;
    logic [FRAME_BITS-1:0]             frame_out_next;
    logic [IDX_W-1:0]                  slot_reg;
    logic [IDX_W-1:0]                  slot_next;
    logic [tlbclk_pkg::COUNT_W-1:0]    total_reg;
    logic [tlbclk_pkg::COUNT_W-1:0]    total_next;

    logic [PAGE_BITS-1:0]              tag_mem [ENTRIES];
    logic [FRAME_BITS-1:0]             frame_mem [ENTRIES];

    logic [ENTRIES-1:0]                active_vec;
    logic [ENTRIES-1:0]                match_vec;
    logic [ENTRIES-1:0]                free_vec;
    logic                              match_any;
    logic [IDX_W-1:0]                  match_idx;
    logic                              free_any;
    logic [IDX_W-1:0]                  free_idx;
    logic [IDX_W-1:0]                  ptr_inc;
    logic                              ptr_last;
    logic                              out_free;
    logic                              write_en;
    logic [IDX_W-1:0]                  write_idx;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_lane
        assign active_vec[i] = (i == 0) || (CMP_W'(i) < CMP_W'(active_entries));
        assign match_vec[i] = active_vec[i] && valid_reg[i] && (tag_mem[i] == page_reg);
        assign free_vec[i] = active_vec[i] && !valid_reg[i];
    end

    always_comb
    begin
        match_any = 1'b0;
        match_idx = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (match_vec[i])
            begin
                match_any = 1'b1;
                match_idx = IDX_W'(i);
            end
            if (free_vec[i])
            begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    assign ptr_inc = ptr_reg + 1'b1;
    assign ptr_last = (ptr_reg == IDX_W'(ENTRIES - 1)) || !active_vec[ptr_inc];
    assign out_free = !out_valid_reg || out_ready;

    assign status.is_fill = kind_reg;
    assign status.has_invalid = free_any;
    assign status.ptr_used = used_reg[ptr_reg];
    assign status.out_free = out_free;

    assign write_en = cmd.fill_free || cmd.fill_victim;
    assign write_idx = cmd.fill_free ? free_idx : ptr_reg;

    always_comb
    begin
        valid_next = valid_reg;
        used_next = used_reg;
        dirty_next = dirty_reg;
        count_next = count_reg;
        ptr_next = ptr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        hit_next = hit_reg;
        frame_out_next = frame_out_reg;
        slot_next = slot_reg;
        total_next = total_reg;

        if (cmd.load)
        begin
            ptr_next = '0;
        end

        if (cmd.lookup_commit)
        begin
            if (match_any)
            begin
                count_next = count_reg + 1'b1;
                used_next[match_idx] = 1'b1;
                if (write_reg)
                begin
                    dirty_next[match_idx] = 1'b1;
                end
            end
            out_valid_next = 1'b1;
            hit_next = match_any;
            frame_out_next = match_any ? frame_mem[match_idx] : '0;
            slot_next = match_any ? match_idx : '0;
            total_next = count_next;
        end

        if (cmd.sweep_clear)
        begin
            used_next[ptr_reg] = 1'b0;
            ptr_next = ptr_last ? '0 : ptr_inc;
        end

        if (write_en)
        begin
            valid_next[write_idx] = 1'b1;
            if (cmd.fill_victim)
            begin
                used_next[write_idx] = 1'b1;
            end
            out_valid_next = 1'b1;
            hit_next = 1'b0;
            frame_out_next = frame_in_reg;
            slot_next = write_idx;
            total_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            used_reg <= '0;
            dirty_reg <= '0;
            count_reg <= '0;
            ptr_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            used_reg <= used_next;
            dirty_reg <= dirty_next;
            count_reg <= count_next;
            ptr_reg <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
        frame_out_reg <= frame_out_next;
        slot_reg <= slot_next;
        total_reg <= total_next;
        if (cmd.load)
        begin
            kind_reg <= kind;
            page_reg <= page_number;
            frame_in_reg <= frame_in;
            write_reg <= write_access;
        end
        if (write_en)
        begin
            tag_mem[write_idx] <= page_reg;
            frame_mem[write_idx] <= frame_in_reg;
        end
    end

    for (genvar b = 0; b < tlbclk_pkg::SLOT_W; b++)
    begin : g_slot
        if (b < IDX_W)
        begin : g_bit
            assign slot[b] = slot_reg[b];
        end
        else
        begin : g_zero
            assign slot[b] = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit = hit_reg;
    assign frame_out = frame_out_reg;
    assign hit_total = total_reg;

endmodule

// File: rtl/tlb_lookup_clock_replacement.sv
// Channel   Direction  Handshake                  Payload
// request   in         in_valid / in_ready        kind, page_number, frame_in, write_access
// result    out        out_valid / out_ready      hit, frame_out, slot, hit_total
// config    in         psel, penable, pwrite      paddr, pwdata, prdata (pready tied high)
//
// A lookup, or a fill into an invalid entry, is decided in the look state and its result is
// registered in the output register; the next request is accepted once the block is idle.
// A fill into a full set clears one used mark per cycle, then replaces the first unused entry.
// A new request is accepted only after the previous result is in the output register.
// A stalled result holds the final step of a request until the output register is free.
// Reset clears all valid, used and dirty marks and the hit counter; no clearing pass is needed.
module tlb_lookup_clock_replacement
#(
    parameter int ENTRIES = 16,
    parameter int PAGE_BITS = 20,
    parameter int FRAME_BITS = 20
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  kind,
    input  logic [PAGE_BITS-1:0]                  page_number,
    input  logic [FRAME_BITS-1:0]                 frame_in,
    input  logic                                  write_access,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  hit,
    output logic [FRAME_BITS-1:0]                 frame_out,
    output logic [tlbclk_pkg::SLOT_W-1:0]         slot,
    output logic [tlbclk_pkg::COUNT_W-1:0]        hit_total,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [tlbclk_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [tlbclk_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [tlbclk_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                  pready
);

    tlbclk_pkg::tlbclk_cmd_t         cmd;
    tlbclk_pkg::tlbclk_status_t      status;
    logic [tlbclk_pkg::CFG_W-1:0]    active_reg;
    logic [tlbclk_pkg::CFG_W-1:0]    active_next;
    logic                            cfg_write;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == tlbclk_pkg::ADDR_ACTIVE_ENTRIES);
    assign active_next = cfg_write ? pwdata[tlbclk_pkg::CFG_W-1:0] : active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= tlbclk_pkg::ACTIVE_ENTRIES_RESET;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        case (paddr)
            tlbclk_pkg::ADDR_ACTIVE_ENTRIES:
            begin
                prdata = tlbclk_pkg::APB_DATA_W'(active_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    tlbclk_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tlbclk_dp
    #(
        .ENTRIES    (ENTRIES),
        .PAGE_BITS  (PAGE_BITS),
        .FRAME_BITS (FRAME_BITS)
    )
    u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .active_entries (active_reg),
        .kind           (kind),
        .page_number    (page_number),
        .frame_in       (frame_in),
        .write_access   (write_access),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .hit            (hit),
        .frame_out      (frame_out),
        .slot           (slot),
        .hit_total      (hit_total)
    );

    // An accepted request closes the input until its result is produced.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while a previous request is still in progress");

    // A fresh result appears only at the end of a request's processing.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(!in_ready) && in_ready))
        else $error("result produced outside the end of a request");

    // A lookup miss always reports a zero frame and slot zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !hit && $rose(out_valid) && $past(cmd.lookup_commit))
        |-> (frame_out == '0 && slot == '0))
        else $error("lookup miss returned a nonzero frame or slot");

endmodule
